[hw/rtl/kmhr_pkg.sv]
// Package: sizes, keymap ROM and shared types for the key matrix report builder.
`default_nettype none
package kmhr_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 8;
    localparam int REPORT_SLOTS = 6;

    localparam int ROW_W      = 3;
    localparam int LEVEL_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 16;
    localparam int OUT_SLOTS  = 6;
    localparam int TABLE_SIZE = 64;
    localparam int TBL_W      = $clog2(TABLE_SIZE);
    localparam int SLOT_CNT_W = $clog2(REPORT_SLOTS + 1);
    localparam int SLOT_IDX_W = $clog2(OUT_SLOTS);
    localparam int POS_W      = $clog2(REPORT_SLOTS + COLUMN_COUNT + 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

    // Running accumulators of one scan
    typedef struct packed {
        logic [BYTE_W-1:0]                  modifier;
        logic [OUT_SLOTS-1:0][BYTE_W-1:0]   slots;
        logic [SLOT_CNT_W-1:0]              used;
        logic                               touched;
    } t_scan_acc;

    // One boot report
    typedef struct packed {
        logic [BYTE_W-1:0]                  modifier;
        logic [OUT_SLOTS-1:0][BYTE_W-1:0]   slots;
    } t_report;

    // Keymap ROM: usage codes, modifiers carry their bit in the high byte
    function automatic logic [CODE_W-1:0] key_code(input logic [TBL_W-1:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            6'd0:  c = 16'd41;   6'd1:  c = 16'd43;   6'd2:  c = 16'h0100; 6'd3:  c = 16'd0;
            6'd4:  c = 16'h0200; 6'd5:  c = 16'd40;   6'd6:  c = 16'd52;   6'd7:  c = 16'd47;
            6'd8:  c = 16'd30;   6'd9:  c = 16'd31;   6'd10: c = 16'd32;   6'd11: c = 16'd33;
            6'd12: c = 16'd34;   6'd13: c = 16'd35;   6'd14: c = 16'd36;   6'd15: c = 16'd37;
            6'd16: c = 16'd20;   6'd17: c = 16'd26;   6'd18: c = 16'd8;    6'd19: c = 16'd21;
            6'd20: c = 16'd23;   6'd21: c = 16'd28;   6'd22: c = 16'd24;   6'd23: c = 16'd12;
            6'd24: c = 16'd4;    6'd25: c = 16'd22;   6'd26: c = 16'd7;    6'd27: c = 16'd9;
            6'd28: c = 16'd10;   6'd29: c = 16'd11;   6'd30: c = 16'd13;   6'd31: c = 16'd14;
            6'd32: c = 16'd29;   6'd33: c = 16'd27;   6'd34: c = 16'd6;    6'd35: c = 16'd25;
            6'd36: c = 16'd5;    6'd37: c = 16'd17;   6'd38: c = 16'd16;   6'd39: c = 16'd54;
            6'd40: c = 16'd82;   6'd41: c = 16'd80;   6'd42: c = 16'd39;   6'd43: c = 16'd44;
            6'd44: c = 16'd55;   6'd45: c = 16'd19;   6'd46: c = 16'd18;   6'd47: c = 16'd38;
            6'd48: c = 16'd79;   6'd49: c = 16'd81;   6'd50: c = 16'd45;   6'd51: c = 16'd56;
            6'd52: c = 16'd51;   6'd53: c = 16'd49;   6'd54: c = 16'd15;   6'd55: c = 16'd46;
            6'd59: c = 16'd57;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/kmhr_ifs.sv]
// Interfaces: row sample channel and report channel.
`default_nettype none
interface kmhr_row_if;
    import kmhr_pkg::*;
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] column_levels;
    modport source (output valid, output row, output column_levels, input ready);
    modport sink   (input valid, input row, input column_levels, output ready);
endinterface

interface kmhr_report_if;
    import kmhr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] modifier_bits;
    logic [BYTE_W-1:0] key_slot0;
    logic [BYTE_W-1:0] key_slot1;
    logic [BYTE_W-1:0] key_slot2;
    logic [BYTE_W-1:0] key_slot3;
    logic [BYTE_W-1:0] key_slot4;
    logic [BYTE_W-1:0] key_slot5;
    modport source (output valid, output modifier_bits, output key_slot0, output key_slot1,
                    output key_slot2, output key_slot3, output key_slot4, output key_slot5,
                    input ready);
    modport sink   (input valid, input modifier_bits, input key_slot0, input key_slot1,
                    input key_slot2, input key_slot3, input key_slot4, input key_slot5,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/kmhr_in_reg.sv]
// Input register stage for row samples.
`default_nettype none
module kmhr_in_reg
    import kmhr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    kmhr_row_if.sink        i_item,
    input  wire logic       i_adv,
    output logic            o_vld,
    output logic [ROW_W-1:0]   o_row,
    output logic [LEVEL_W-1:0] o_levels
);

    logic               r_vld;
    logic [ROW_W-1:0]   r_row;
    logic [LEVEL_W-1:0] r_levels;

    // slot frees when held item moves on this cycle
    assign i_item.ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_row    <= i_item.row;
            r_levels <= i_item.column_levels;
        end
    end

    assign o_vld    = r_vld;
    assign o_row    = r_row;
    assign o_levels = r_levels;

endmodule
`default_nettype wire

[hw/rtl/kmhr_row_eval.sv]
// Per-row evaluation: keymap lookup, modifier merge, slot allocation, change detect.
`default_nettype none
module kmhr_row_eval
    import kmhr_pkg::*;
(
    input  wire logic [ROW_W-1:0]        i_row,
    input  wire logic [LEVEL_W-1:0]      i_levels,
    input  wire logic [COLUMN_COUNT-1:0] i_pressed,
    input  wire t_scan_acc               i_acc,
    output t_scan_acc                    o_acc,
    output logic [COLUMN_COUNT-1:0]      o_pressed,
    output logic                         o_emit,
    output t_report                      o_report
);

    logic [COLUMN_COUNT-1:0][CODE_W-1:0] w_code;
    logic [COLUMN_COUNT-1:0]             w_key;
    logic [COLUMN_COUNT-1:0]             w_down;
    t_scan_acc                           w_acc;
    logic [POS_W-1:0]                    w_cnt;
    logic                                w_in_range;
    logic                                w_last;

    always_comb begin
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            if (int'(i_row) * COLUMN_COUNT + c < TABLE_SIZE) begin
                w_code[c] = key_code(TBL_W'(int'(i_row) * COLUMN_COUNT + c));
            end else begin
                w_code[c] = '0;
            end
            w_key[c] = (w_code[c] != '0);
            // columns without a line read as released
            if (c < LEVEL_W) begin
                w_down[c] = w_key[c] && !i_levels[c];
            end else begin
                w_down[c] = 1'b0;
            end
        end
    end

    always_comb begin
        w_acc = i_acc;
        w_cnt = POS_W'(i_acc.used);
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            if (w_key[c] && (w_down[c] != i_pressed[c])) begin
                w_acc.touched = 1'b1;
            end
            if (w_down[c]) begin
                w_acc.touched = 1'b1;
                if (w_code[c][CODE_W-1:BYTE_W] != '0) begin
                    w_acc.modifier = w_acc.modifier | w_code[c][CODE_W-1:BYTE_W];
                end else if (w_cnt < POS_W'(REPORT_SLOTS)) begin
                    w_acc.slots[w_cnt[SLOT_IDX_W-1:0]] = w_code[c][BYTE_W-1:0];
                    w_cnt = w_cnt + POS_W'(1);
                end
            end
        end
        w_acc.used = w_cnt[SLOT_CNT_W-1:0];
    end

    always_comb begin
        w_in_range = int'(i_row) < ROW_COUNT;
        w_last     = (i_row == LAST_ROW);
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            o_pressed[c] = (w_in_range && w_key[c]) ? w_down[c] : i_pressed[c];
        end
        o_report.modifier = w_acc.modifier;
        o_report.slots    = w_acc.slots;
        o_emit            = w_in_range && w_last && w_acc.touched;
        if (!w_in_range) begin
            o_acc = i_acc;
        end else if (w_last) begin
            o_acc = '0;
        end else begin
            o_acc = w_acc;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/kmhr_report_reg.sv]
// Output register holding one finished report until the sink takes it.
`default_nettype none
module kmhr_report_reg
    import kmhr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_report  i_report,
    output logic          o_free,
    kmhr_report_if.source o_report
);

    logic    r_vld;
    t_report r_report;

    assign o_free = !r_vld || o_report.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_report <= i_report;
        end
    end

    assign o_report.valid         = r_vld;
    assign o_report.modifier_bits = r_report.modifier;
    assign o_report.key_slot0     = r_report.slots[0];
    assign o_report.key_slot1     = r_report.slots[1];
    assign o_report.key_slot2     = r_report.slots[2];
    assign o_report.key_slot3     = r_report.slots[3];
    assign o_report.key_slot4     = r_report.slots[4];
    assign o_report.key_slot5     = r_report.slots[5];

endmodule
`default_nettype wire

[hw/rtl/key_matrix_hid_report_builder.sv]
// A row sample transaction is registered, then evaluated; its report goes to an output register.
// Throughput: one row per cycle; the only stall is a finished report the sink has not yet taken.
// The combinational evaluation (ROM lookup, 8-column prefix count into six slots) sets the pace.
// Reset (i_rst_n low, synchronous): key state, accumulators and both valid flags cleared.
// Reports go out only for scans that saw a press or a change, at the last row.
`default_nettype none
module key_matrix_hid_report_builder
    import kmhr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kmhr_row_if.sink      i_item,
    kmhr_report_if.source o_report
);

    // Input stage outputs
    logic               w_in_vld;
    logic [ROW_W-1:0]   w_row;
    logic [LEVEL_W-1:0] w_levels;

    // Scan state
    logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] r_pressed;
    t_scan_acc                              r_acc;

    // Evaluation results
    t_scan_acc                 n_acc;
    logic [COLUMN_COUNT-1:0]   n_pressed_row;
    logic [COLUMN_COUNT-1:0]   w_pressed_row;
    logic                      w_emit;
    t_report                   w_report;
    logic                      w_out_free;
    logic                      w_adv;

    kmhr_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_adv    (w_adv),
        .o_vld    (w_in_vld),
        .o_row    (w_row),
        .o_levels (w_levels)
    );

    // Out-of-range rows read no pressed keys here and are also masked inside the evaluator
    assign w_pressed_row = (int'(w_row) < ROW_COUNT) ? r_pressed[w_row] : '0;

    kmhr_row_eval u_row_eval (
        .i_row     (w_row),
        .i_levels  (w_levels),
        .i_pressed (w_pressed_row),
        .i_acc     (r_acc),
        .o_acc     (n_acc),
        .o_pressed (n_pressed_row),
        .o_emit    (w_emit),
        .o_report  (w_report)
    );

    // A row moves on unless it owes a report and the output register is still occupied
    assign w_adv = w_in_vld && (!w_emit || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
            r_acc     <= '0;
        end else if (w_adv) begin
            r_acc <= n_acc;
            if (int'(w_row) < ROW_COUNT) begin
                r_pressed[w_row] <= n_pressed_row;
            end
        end
    end

    kmhr_report_reg u_report_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv && w_emit),
        .i_report (w_report),
        .o_free   (w_out_free),
        .o_report (o_report)
    );

    // Slot fill count never passes the report width
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc.used <= SLOT_CNT_W'(REPORT_SLOTS))
        else $error("slot count beyond report width");

    // Nothing gathered without the scan being marked touched
    a_untouched_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc.touched |-> (r_acc.used == '0 && r_acc.modifier == '0))
        else $error("accumulators hold data in an untouched scan");

    // Closing row clears the accumulators
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_row == LAST_ROW) |=> (r_acc == '0))
        else $error("accumulators not cleared after last row");

    // A new report only appears from an advancing closing row
    a_report_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_report.valid && !$past(o_report.valid)) |-> $past(w_adv && w_emit))
        else $error("report appeared without a closing row");

endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for key_matrix_hid_report_builder: row scans checked against a scan predictor.
module testbench;
    import kmhr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES    = 400;   // long report back-pressure stretch
    localparam int DRAIN_CYCLES   = 10;    // settle time after the last report
    localparam int RANDOM_ROWS    = 500;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,  // expectation from the predictor
        CHK_NONE,   // no report may follow
        CHK_TYPED   // expectation written into the table
    } t_check;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        t_check             check;
        t_report            want;
    } t_row_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kmhr_row_if    row_bus ();
    kmhr_report_if rep_bus ();

    key_matrix_hid_report_builder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (row_bus),
        .o_report (rep_bus)
    );

    always #4 i_clk = ~i_clk;

    // Keymap: usage codes, modifiers carry their bit in the high byte, 0 = no key
    logic [CODE_W-1:0] usage_rom [TABLE_SIZE] = '{
        16'd41,  16'd43,  16'h0100, 16'd0,  16'h0200, 16'd40, 16'd52, 16'd47,
        16'd30,  16'd31,  16'd32,   16'd33, 16'd34,   16'd35, 16'd36, 16'd37,
        16'd20,  16'd26,  16'd8,    16'd21, 16'd23,   16'd28, 16'd24, 16'd12,
        16'd4,   16'd22,  16'd7,    16'd9,  16'd10,   16'd11, 16'd13, 16'd14,
        16'd29,  16'd27,  16'd6,    16'd25, 16'd5,    16'd17, 16'd16, 16'd54,
        16'd82,  16'd80,  16'd39,   16'd44, 16'd55,   16'd19, 16'd18, 16'd38,
        16'd79,  16'd81,  16'd45,   16'd56, 16'd51,   16'd49, 16'd15, 16'd46,
        16'd0,   16'd0,   16'd0,    16'd57, 16'd0,    16'd0,  16'd0,  16'd0
    };

    // Predictor state
    logic [COLUMN_COUNT-1:0] seen_down [ROW_COUNT];
    logic [BYTE_W-1:0]       mod_acc;
    logic [BYTE_W-1:0]       slot_acc [OUT_SLOTS];
    int                      slot_fill;
    bit                      scan_active;

    t_report   pending_reports [$];
    t_row_step directed [$];
    int        mismatches = 0;
    int        rows_sent = 0;
    int        quiet_cycles = 0;
    int        src_idle_pct = 21;
    int        snk_idle_pct = 73;
    bit        hold_req = 1'b0;

    function automatic void clear_scan();
        mod_acc     = '0;
        slot_fill   = 0;
        scan_active = 1'b0;
        for (int j = 0; j < OUT_SLOTS; j++)
            slot_acc[j] = '0;
    endfunction

    // Folds one row sample into the running scan; returns 1 when a report is due
    function automatic bit scan_row(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] lv,
                                    output t_report rep);
        logic [CODE_W-1:0] code;
        bit now_down;
        bit emit;
        emit = 1'b0;
        rep  = '0;
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            code = usage_rom[r * COLUMN_COUNT + c];
            if (code != '0) begin
                now_down = !lv[c];
                if (now_down != seen_down[r][c])
                    scan_active = 1'b1;
                if (now_down) begin
                    scan_active = 1'b1;
                    if (code > 16'h00ff)
                        mod_acc = mod_acc | code[15:8];
                    else if (slot_fill < REPORT_SLOTS) begin
                        slot_acc[slot_fill] = code[7:0];
                        slot_fill++;
                    end
                end
                seen_down[r][c] = now_down;
            end
        end
        if (r == LAST_ROW) begin
            if (scan_active) begin
                emit = 1'b1;
                rep.modifier = mod_acc;
                for (int j = 0; j < OUT_SLOTS; j++)
                    rep.slots[j] = slot_acc[j];
            end
            clear_scan();
        end
        return emit;
    endfunction

    function automatic t_report report_of(input logic [7:0] m, input logic [7:0] s0,
                                          input logic [7:0] s1, input logic [7:0] s2,
                                          input logic [7:0] s3, input logic [7:0] s4,
                                          input logic [7:0] s5);
        t_report rep;
        rep.modifier = m;
        rep.slots[0] = s0;
        rep.slots[1] = s1;
        rep.slots[2] = s2;
        rep.slots[3] = s3;
        rep.slots[4] = s4;
        rep.slots[5] = s5;
        return rep;
    endfunction

    function automatic void add_step(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] lv,
                                     input t_check chk, input t_report want);
        t_row_step s;
        s.row    = r;
        s.levels = lv;
        s.check  = chk;
        s.want   = want;
        directed.push_back(s);
    endfunction

    // Offers one row sample, with random idle cycles first, and books its expectation
    task automatic send_row(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] lv,
                            input t_check chk, input t_report typed);
        t_report pred;
        bit fired;
        while ($urandom_range(99) < src_idle_pct) begin
            row_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_bus.valid         <= 1'b1;
        row_bus.row           <= r;
        row_bus.column_levels <= lv;
        @(posedge i_clk);
        while (!row_bus.ready)
            @(posedge i_clk);
        fired = scan_row(r, lv, pred);
        case (chk)
            CHK_MODEL: if (fired) pending_reports.push_back(pred);
            CHK_TYPED: pending_reports.push_back(typed);
            default: ;
        endcase
        rows_sent++;
    endtask

    // Report sink: random back-pressure, plus one long hold on request
    initial begin
        rep_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rep_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rep_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && rep_bus.valid && rep_bus.ready) begin
            got = report_of(rep_bus.modifier_bits, rep_bus.key_slot0, rep_bus.key_slot1,
                            rep_bus.key_slot2, rep_bus.key_slot3, rep_bus.key_slot4,
                            rep_bus.key_slot5);
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %h", $time, got);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (got.modifier !== want.modifier) begin
                    $display("%0t: modifier_bits expected %h got %h",
                             $time, want.modifier, got.modifier);
                    mismatches++;
                end
                for (int j = 0; j < OUT_SLOTS; j++) begin
                    if (got.slots[j] !== want.slots[j]) begin
                        $display("%0t: key_slot%0d expected %h got %h",
                                 $time, j, want.slots[j], got.slots[j]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: any stretch with no transaction on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (row_bus.valid && row_bus.ready) || (rep_bus.valid && rep_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int kind;
        int n;
        int random_start;
        bit pressure_done;
        logic [LEVEL_W-1:0] held [ROW_COUNT];

        row_bus.valid         = 1'b0;
        row_bus.row           = '0;
        row_bus.column_levels = '1;
        for (int r = 0; r < ROW_COUNT; r++) begin
            seen_down[r] = '0;
            held[r]      = '0;
        end
        clear_scan();
        pressure_done = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle matrix after reset: no report
        for (int r = 0; r < ROW_COUNT - 1; r++)
            add_step(ROW_W'(r), 8'hff, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_NONE, '0);
        // Whole first row down: Ctrl, Shift, five usage codes, unmapped column skipped
        add_step(ROW_W'(0), 8'h00, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_TYPED,
                 report_of(8'h03, 8'd41, 8'd43, 8'd40, 8'd52, 8'd47, 8'd0));
        // Eight codes into six slots, last-row key dropped but still counts as a press
        add_step(ROW_W'(1), 8'h00, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'h00, CHK_TYPED,
                 report_of(8'h00, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35));
        // Held key seen again on its own: takes the first slot
        add_step(LAST_ROW, 8'h00, CHK_TYPED,
                 report_of(8'h00, 8'd57, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // Releases alone touch the scan: empty report
        add_step(ROW_W'(0), 8'hff, CHK_MODEL, '0);
        add_step(ROW_W'(1), 8'hff, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_TYPED, '0);
        // Only the unmapped column pressed: nothing to report
        add_step(ROW_W'(0), 8'hf7, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_NONE, '0);
        // Both modifiers with full slots
        add_step(ROW_W'(0), 8'heb, CHK_MODEL, '0);
        add_step(ROW_W'(1), 8'h00, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_TYPED,
                 report_of(8'h03, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35));
        // Top column of a middle row, rows out of order
        add_step(ROW_W'(2), 8'h7f, CHK_MODEL, '0);
        add_step(LAST_ROW, 8'hff, CHK_MODEL, '0);

        foreach (directed[k])
            send_row(directed[k].row, directed[k].levels, directed[k].check, directed[k].want);

        // Random scans: mostly complete 0..7 sweeps over a slowly changing set of held keys
        random_start = rows_sent;
        while (rows_sent - random_start < RANDOM_ROWS) begin
            if (rows_sent - random_start < RANDOM_ROWS / 3) begin
                src_idle_pct = 21;
                snk_idle_pct = 73;
            end else if (rows_sent - random_start < 2 * RANDOM_ROWS / 3) begin
                src_idle_pct = 73;
                snk_idle_pct = 21;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                if (!pressure_done) begin
                    // Sink holds off while every scan carries a press: the block must stall
                    pressure_done = 1'b1;
                    hold_req = 1'b1;
                    repeat (6) begin
                        for (int r = 0; r < ROW_COUNT; r++)
                            send_row(ROW_W'(r),
                                     (r == 0) ? (8'($urandom) & 8'hfe) : 8'($urandom),
                                     CHK_MODEL, '0);
                    end
                end
            end

            kind = $urandom_range(9);
            case (kind)
                0, 1: for (int r = 0; r < ROW_COUNT; r++) held[r] = '0;
                2, 3, 4, 5:
                    for (int r = 0; r < ROW_COUNT; r++)
                        if ($urandom_range(3) == 0)
                            held[r] = held[r] ^ (8'd1 << $urandom_range(7));
                7: for (int r = 0; r < ROW_COUNT; r++) held[r] = 8'($urandom);
                8: for (int r = 0; r < ROW_COUNT; r++) held[r] = '1;
                default: ;
            endcase

            if (kind == 9) begin
                // Broken sweep: a few rows in any order
                n = $urandom_range(8, 1);
                repeat (n)
                    send_row(ROW_W'($urandom_range(ROW_COUNT - 1)), 8'($urandom), CHK_MODEL, '0);
            end else begin
                for (int r = 0; r < ROW_COUNT; r++)
                    send_row(ROW_W'(r), ~held[r], CHK_MODEL, '0);
            end
        end
        row_bus.valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[key_matrix_hid_report_builder.f]
hw/rtl/kmhr_pkg.sv
hw/rtl/kmhr_ifs.sv
hw/rtl/kmhr_in_reg.sv
hw/rtl/kmhr_row_eval.sv
hw/rtl/kmhr_report_reg.sv
hw/rtl/key_matrix_hid_report_builder.sv
sim/testbench.sv
